FILE: sv/utf8_to_codepoint_decoder_macros.svh
// Assertion helpers for the UTF-8 decoder.
`ifndef UTF8_TO_CODEPOINT_DECODER_MACROS_SVH
`define UTF8_TO_CODEPOINT_DECODER_MACROS_SVH

// Check prop at every rising edge outside reset.
`define U8CP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("u8cp assertion failed");

// Check that cond never holds outside reset.
`define U8CP_NEVER(label, clk, rst_n, cond) \
    `U8CP_ASSERT(label, clk, rst_n, !(cond))

`endif

FILE: sv/u8cp_pkg.sv
`timescale 1ns / 1ps

package u8cp_pkg;

    localparam int unsigned CpWidth   = 31;
    localparam int unsigned ByteWidth = 8;

    typedef logic [2:0]           t_count;
    typedef logic [CpWidth-1:0]   t_code_point;
    typedef logic [ByteWidth-1:0] t_byte;

    localparam t_count LenSix   = 3'd5;
    localparam t_count LenFive  = 3'd4;
    localparam t_count LenFour  = 3'd3;
    localparam t_count LenThree = 3'd2;
    localparam t_count LenTwo   = 3'd1;
    localparam t_count LenOne   = 3'd0;

    localparam t_byte ContMask = 8'h3F;

endpackage

FILE: sv/utf8_to_codepoint_decoder.sv
`timescale 1ns / 1ps
// Data path: an input beat passes through the input register, then the result register, on its way to a result beat.
// Throughput: one byte per cycle; a result beat follows the last byte of each sequence.
// Stalls only when the result register is full and not taken.
// Reset (synchronous, active low) clears both registers' valid flags and the decode state.

`include "utf8_to_codepoint_decoder_macros.svh"

module utf8_to_codepoint_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_code_point
);

    logic                     r_in_valid;
    u8cp_pkg::t_byte          r_in_byte;
    u8cp_pkg::t_count         r_bytes_left;
    u8cp_pkg::t_count         n_bytes_left;
    u8cp_pkg::t_code_point    r_partial;
    u8cp_pkg::t_code_point    n_partial;
    logic                     r_out_valid;
    u8cp_pkg::t_code_point    r_code_point;
    logic                     n_emit;
    u8cp_pkg::t_code_point    n_code_point;
    logic                     adv;
    logic                     fire;
    logic                     lead_take;
    logic                     last_take;

    assign adv        = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_partial    = r_partial;
        n_emit       = 1'b0;
        n_code_point = r_partial;
        if (r_bytes_left != u8cp_pkg::LenOne) begin
            n_partial    = {r_partial[u8cp_pkg::CpWidth-7:0],
                            r_in_byte[5:0] & u8cp_pkg::ContMask[5:0]};
            n_bytes_left = r_bytes_left - 3'd1;
            n_emit       = (r_bytes_left == u8cp_pkg::LenTwo);
            n_code_point = n_partial;
        end else begin
            unique case (r_in_byte) inside
                [8'hFC:8'hFF]: begin
                    n_partial    = u8cp_pkg::t_code_point'(r_in_byte[0]);
                    n_bytes_left = u8cp_pkg::LenSix;
                end
                [8'hF8:8'hFB]: begin
                    n_partial    = u8cp_pkg::t_code_point'(r_in_byte[1:0]);
                    n_bytes_left = u8cp_pkg::LenFive;
                end
                [8'hF0:8'hF7]: begin
                    n_partial    = u8cp_pkg::t_code_point'(r_in_byte[2:0]);
                    n_bytes_left = u8cp_pkg::LenFour;
                end
                [8'hE0:8'hEF]: begin
                    n_partial    = u8cp_pkg::t_code_point'(r_in_byte[3:0]);
                    n_bytes_left = u8cp_pkg::LenThree;
                end
                [8'hC0:8'hDF]: begin
                    n_partial    = u8cp_pkg::t_code_point'(r_in_byte[4:0]);
                    n_bytes_left = u8cp_pkg::LenTwo;
                end
                default: begin
                    n_partial    = '0;
                    n_bytes_left = u8cp_pkg::LenOne;
                    n_emit       = 1'b1;
                    n_code_point = u8cp_pkg::t_code_point'(r_in_byte);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bytes_left <= u8cp_pkg::LenOne;
            r_partial    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= fire && n_emit;
            end
            if (fire) begin
                r_bytes_left <= n_bytes_left;
                r_partial    <= n_partial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
        if (fire && n_emit) begin
            r_code_point <= n_code_point;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;

    assign lead_take = fire && r_bytes_left == u8cp_pkg::LenOne && r_in_byte >= 8'hC0;
    assign last_take = fire && r_bytes_left == u8cp_pkg::LenTwo;

    `U8CP_NEVER(a_left_range, i_clk, i_rst_n, r_bytes_left > u8cp_pkg::LenSix)
    `U8CP_ASSERT(a_lead_silent, i_clk, i_rst_n, lead_take |=> !o_out_valid)
    `U8CP_ASSERT(a_last_emits, i_clk, i_rst_n, last_take |=> o_out_valid)

endmodule
